// ===== hdl/dba_pkg.sv =====
// Shared types, constants and helpers for the disk block allocator.
package dba_pkg;

    // Store geometry
    localparam int NUM_BLOCKS = 128;
    localparam int MAX_LENGTH = 63;
    localparam int BLK_W      = $clog2(NUM_BLOCKS);
    localparam int LEN_W      = 6;
    localparam int WORD_W     = 16;
    localparam int WBIT_W     = $clog2(WORD_W);
    localparam int NUM_WORDS  = NUM_BLOCKS / WORD_W;
    localparam int WADDR_W    = $clog2(NUM_WORDS);

    // Request commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Allocation modes
    localparam logic MODE_CONTIG  = 1'b0;
    localparam logic MODE_INDEXED = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_BUSY = 2'd1,
        ST_RUN  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CHECK,
        S_MARK,
        S_FETCH,
        S_LOAD,
        S_SCAN
    } state_t;

    // Access request from the controller to the bitmap store
    typedef struct packed {
        logic               clear;
        logic               rd_en;
        logic [WADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
    } map_req_t;

    // Lowest free bit of one bitmap word
    typedef struct packed {
        logic              found;
        logic [WBIT_W-1:0] idx;
    } free_t;

    function automatic free_t find_free(input logic [WORD_W-1:0] w);
        free_t r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r.found = 1'b1;
                r.idx   = WBIT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== hdl/dba_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module dba_ram #(
    parameter int DATA_W = 16,
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    assign rd_data = q_reg;

endmodule

// ===== hdl/dba_map.sv =====
// Block bitmap store: word RAM plus per-word valid bits, so a clear needs no RAM pass.
module dba_map (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dba_pkg::map_req_t              req,
    output logic [dba_pkg::WORD_W-1:0]     rd_word
);
    import dba_pkg::*;

    logic [NUM_WORDS-1:0] vld_reg;
    logic [NUM_WORDS-1:0] vld_next;
    logic                 rd_vld_reg;
    logic [WORD_W-1:0]    ram_q;

    dba_ram #(
        .DATA_W (WORD_W),
        .ADDR_W (WADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr),
        .wr_data (req.wr_data),
        .rd_en   (req.rd_en),
        .rd_addr (req.rd_addr),
        .rd_data (ram_q)
    );

    // Word valid bits: a word never written since reset or the last clear reads as free
    always_comb
    begin
        vld_next = vld_reg;
        if (req.clear)
        begin
            vld_next = '0;
        end
        else if (req.wr_en)
        begin
            vld_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_word = rd_vld_reg ? ram_q : '0;

endmodule

// ===== hdl/dba_ctrl.sv =====
// Request sequencer: run check, run marking, free-block scan and result register.
module dba_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [dba_pkg::BLK_W-1:0]       start_block,
    input  logic [dba_pkg::LEN_W-1:0]       length,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic [dba_pkg::BLK_W-1:0]       block,
    output logic                            last,
    output dba_pkg::map_req_t               map_req,
    input  logic [dba_pkg::WORD_W-1:0]      rd_word
);
    import dba_pkg::*;

    state_t              state_reg, state_next;
    logic                mode_reg;
    logic [BLK_W-1:0]    start_reg, start_next;
    logic [BLK_W:0]      end_reg, end_next;
    logic [LEN_W-1:0]    cnt_reg, cnt_next;
    logic [WADDR_W-1:0]  cw_reg, cw_next;
    logic [WORD_W-1:0]   wbuf_reg, wbuf_next;
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [BLK_W-1:0]    block_reg, block_next;
    logic                last_reg, last_next;

    logic                accept;
    logic                out_free;
    logic [WADDR_W-1:0]  start_word;
    logic [WBIT_W-1:0]   start_bit;
    logic [BLK_W:0]      end_m1;
    logic [WADDR_W-1:0]  last_word;
    logic                rng_bad;
    logic                over;
    logic                busy;
    logic [WORD_W-1:0]   run_mask;
    logic                hit;
    logic                at_last;
    logic [WORD_W-1:0]   excl;
    free_t               fr;
    logic                at_top;

    logic                emit;
    status_t             emit_status;
    logic [BLK_W-1:0]    emit_block;
    logic                emit_last;

    // Shared conditions
    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign start_word = start_reg[BLK_W-1:WBIT_W];
    assign start_bit  = start_reg[WBIT_W-1:0];
    assign end_m1     = end_reg - (BLK_W+1)'(1);
    assign last_word  = end_m1[BLK_W-1:WBIT_W];
    assign rng_bad    = ({1'b0, start_reg} >= (BLK_W+1)'(NUM_BLOCKS))
                        || (cnt_reg > LEN_W'(MAX_LENGTH));
    assign over       = end_reg > (BLK_W+1)'(NUM_BLOCKS);
    assign busy       = rd_word[start_bit];
    assign hit        = (rd_word & run_mask) != '0;
    assign at_last    = (cw_reg == last_word);
    assign excl       = (cw_reg == '0) ? WORD_W'(1) : '0;
    assign fr         = find_free(wbuf_reg | excl);
    assign at_top     = (cw_reg == WADDR_W'(NUM_WORDS - 1));

    // Bits of the current word that fall inside the requested run
    always_comb
    begin
        logic [BLK_W:0] idx;
        for (int i = 0; i < WORD_W; i++)
        begin
            idx         = {1'b0, cw_reg, WBIT_W'(i)};
            run_mask[i] = (idx >= {1'b0, start_reg}) && (idx < end_reg);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && command == CMD_ALLOC)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (rng_bad || busy)
                begin
                    if (out_free) state_next = S_IDLE;
                end
                else if (mode_reg == MODE_CONTIG)
                begin
                    if (over || cnt_reg == '0)
                    begin
                        if (out_free) state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
                else if (out_free)
                begin
                    state_next = (cnt_reg == '0) ? S_IDLE : S_FETCH;
                end
            end
            S_CHECK:
            begin
                if (hit)
                begin
                    if (out_free) state_next = S_IDLE;
                end
                else if (at_last)
                begin
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                if (at_last && out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (fr.found)
                begin
                    if (out_free && cnt_reg == LEN_W'(1)) state_next = S_IDLE;
                end
                else if (at_top)
                begin
                    if (out_free) state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_FETCH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, store accesses and result loads
    always_comb
    begin
        start_next  = start_reg;
        end_next    = end_reg;
        cnt_next    = cnt_reg;
        cw_next     = cw_reg;
        wbuf_next   = wbuf_reg;
        map_req     = '0;
        emit        = 1'b0;
        emit_status = ST_OK;
        emit_block  = start_reg;
        emit_last   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_CLEAR)
                    begin
                        map_req.clear = 1'b1;
                    end
                    else
                    begin
                        start_next      = start_block;
                        end_next        = {1'b0, start_block} + (BLK_W+1)'(length);
                        cnt_next        = length;
                        cw_next         = start_block[BLK_W-1:WBIT_W];
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = start_block[BLK_W-1:WBIT_W];
                    end
                end
            end
            S_START:
            begin
                if (rng_bad)
                begin
                    emit        = out_free;
                    emit_status = ST_RUN;
                end
                else if (busy)
                begin
                    emit        = out_free;
                    emit_status = ST_BUSY;
                end
                else if (mode_reg == MODE_CONTIG)
                begin
                    if (over)
                    begin
                        emit        = out_free;
                        emit_status = ST_RUN;
                    end
                    else if (cnt_reg == '0)
                    begin
                        emit = out_free;
                    end
                end
                else if (out_free)
                begin
                    // index block taken, scan starts at word zero
                    emit            = 1'b1;
                    emit_last       = (cnt_reg == '0);
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = start_word;
                    map_req.wr_data = rd_word | (WORD_W'(1) << start_bit);
                    cw_next         = '0;
                end
            end
            S_CHECK:
            begin
                if (hit)
                begin
                    emit        = out_free;
                    emit_status = ST_RUN;
                end
                else if (at_last)
                begin
                    map_req.rd_en   = 1'b1;
                    map_req.rd_addr = start_word;
                    cw_next         = start_word;
                end
                else
                begin
                    map_req.rd_en   = 1'b1;
                    map_req.rd_addr = cw_reg + WADDR_W'(1);
                    cw_next         = cw_reg + WADDR_W'(1);
                end
            end
            S_MARK:
            begin
                if (!at_last || out_free)
                begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_addr = cw_reg;
                    map_req.wr_data = rd_word | run_mask;
                end
                if (at_last)
                begin
                    emit = out_free;
                end
                else
                begin
                    map_req.rd_en   = 1'b1;
                    map_req.rd_addr = cw_reg + WADDR_W'(1);
                    cw_next         = cw_reg + WADDR_W'(1);
                end
            end
            S_FETCH:
            begin
                map_req.rd_en   = 1'b1;
                map_req.rd_addr = cw_reg;
            end
            S_LOAD:
            begin
                wbuf_next = rd_word;
            end
            S_SCAN:
            begin
                if (fr.found)
                begin
                    if (out_free)
                    begin
                        wbuf_next       = wbuf_reg | (WORD_W'(1) << fr.idx);
                        map_req.wr_en   = 1'b1;
                        map_req.wr_addr = cw_reg;
                        map_req.wr_data = wbuf_next;
                        emit            = 1'b1;
                        emit_block      = {cw_reg, fr.idx};
                        emit_last       = (cnt_reg == LEN_W'(1));
                        cnt_next        = cnt_reg - LEN_W'(1);
                    end
                end
                else if (at_top)
                begin
                    emit        = out_free;
                    emit_status = ST_FULL;
                    emit_block  = '0;
                end
                else
                begin
                    cw_next = cw_reg + WADDR_W'(1);
                end
            end
            default:
            begin
                map_req = '0;
            end
        endcase
    end

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        block_next     = block_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            status_next    = emit_status;
            block_next     = emit_block;
            last_next      = emit_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_CONTIG;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg  <= start_next;
        end_reg    <= end_next;
        cnt_reg    <= cnt_next;
        cw_reg     <= cw_next;
        wbuf_reg   <= wbuf_next;
        status_reg <= status_next;
        block_reg  <= block_next;
        last_reg   <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign block     = block_reg;
    assign last      = last_reg;

endmodule

// ===== hdl/disk_block_allocator.sv =====
// Disk block allocator top level: sequencer plus bitmap store.
//
// Usage:
//   Requests enter on the in channel (in_valid/in_ready) with command,
//   start_block and length; results leave on the out channel
//   (out_valid/out_ready) as status, block and last. A clear command empties
//   the map and gives no result. alloc_mode is written through
//   cfg_we/cfg_wdata, 0 contiguous, 1 indexed; the user must write it only
//   while the block is idle, which the block itself does not enforce. One
//   request is worked at a time; in_ready is high only when idle. The map is
//   8 words of 16 bits in a RAM with a registered read port. Contiguous: a
//   refused start or an empty run is answered from the first word read; each
//   other run is read and checked word by word, then read again and marked.
//   Indexed: the index block is marked first; then each word scanned is
//   fetched and loaded, its free data blocks are taken lowest first, and a
//   word with none is stepped past. The result register lets the next
//   request be taken while a result waits; a new result holds until the
//   slot frees. Reset clears the per-word valid bits, so the whole map reads
//   free at once, with no clearing pass; alloc_mode resets to contiguous.
module disk_block_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        command,
    input  logic [dba_pkg::BLK_W-1:0]   start_block,
    input  logic [dba_pkg::LEN_W-1:0]   length,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [dba_pkg::BLK_W-1:0]   block,
    output logic                        last
);
    import dba_pkg::*;

    map_req_t          map_req;
    logic [WORD_W-1:0] rd_word;

    dba_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .start_block (start_block),
        .length      (length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .block       (block),
        .last        (last),
        .map_req     (map_req),
        .rd_word     (rd_word)
    );

    dba_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (map_req),
        .rd_word (rd_word)
    );

endmodule

// ===== tb/tb_disk_block_allocator.sv =====
// Self-checking testbench for the disk block allocator: bitmap predictor, scoreboard, stimulus.
module tb_disk_block_allocator;
    import dba_pkg::*;

    localparam int SETTLE      = 40;    // cycles the block may still be busy after its last result
    localparam int STALL_LIMIT = 3000;  // cycles with no item moving before the run is abandoned
    localparam int RAND_ITEMS  = 78;
    localparam int PHASES      = 6;

    // One expected result item
    typedef struct packed {
        status_t             status;
        logic [BLK_W-1:0]    block;
        logic                last;
    } alloc_result_t;

    // Bitmap predictor plus the queue of results still owed by the block
    class alloc_scoreboard;
        bit [NUM_BLOCKS-1:0] used_map;
        logic                mode;
        alloc_result_t       owed[$];

        function new();
            used_map = '0;
            mode     = MODE_CONTIG;
        endfunction

        function void owe(status_t st, int blk, bit lst);
            alloc_result_t r;
            r.status = st;
            r.block  = blk[BLK_W-1:0];
            r.last   = lst;
            owed.push_back(r);
        endfunction

        // Work out the results of one accepted request item
        function void note_request(logic cmd, logic [BLK_W-1:0] start, logic [LEN_W-1:0] len);
            int  s;
            int  n;
            int  j;
            int  b;
            bit  found;
            s = int'(start);
            n = int'(len);
            if (cmd == CMD_CLEAR) begin
                used_map = '0;
                return;
            end
            if (s >= NUM_BLOCKS || n > MAX_LENGTH) begin
                owe(ST_RUN, s, 1'b1);
                return;
            end
            if (used_map[s]) begin
                owe(ST_BUSY, s, 1'b1);
                return;
            end
            if (mode == MODE_CONTIG) begin
                if (s + n > NUM_BLOCKS) begin
                    owe(ST_RUN, s, 1'b1);
                    return;
                end
                for (j = s; j < s + n; j++) begin
                    if (used_map[j]) begin
                        owe(ST_RUN, s, 1'b1);
                        return;
                    end
                end
                for (j = s; j < s + n; j++)
                    used_map[j] = 1'b1;
                owe(ST_OK, s, 1'b1);
                return;
            end
            // Indexed: index block first, then lowest free data blocks from block 1
            used_map[s] = 1'b1;
            owe(ST_OK, s, n == 0);
            for (j = 0; j < n; j++) begin
                found = 1'b0;
                for (b = 1; b < NUM_BLOCKS && !found; b++) begin
                    if (!used_map[b]) begin
                        found = 1'b1;
                        used_map[b] = 1'b1;
                        owe(ST_OK, b, j + 1 == n);
                    end
                end
                if (!found) begin
                    owe(ST_FULL, 0, 1'b1);
                    return;
                end
            end
        endfunction

        // Compare one accepted result item with the oldest one owed
        function bit check_result(logic [1:0] st, logic [BLK_W-1:0] blk, logic lst,
                                  output string msg);
            alloc_result_t e;
            msg = "";
            if (owed.size() == 0) begin
                msg = $sformatf("unexpected result: status %0d block %0d last %0d", st, blk, lst);
                return 1'b0;
            end
            e = owed.pop_front();
            if (st !== e.status || blk !== e.block || lst !== e.last) begin
                msg = $sformatf("result mismatch: status %0d/%0d block %0d/%0d last %0d/%0d",
                                st, e.status, blk, e.block, lst, e.last);
                return 1'b0;
            end
            return 1'b1;
        endfunction
    endclass

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               cfg_we      = 1'b0;
    logic               cfg_wdata   = 1'b0;
    logic               in_valid    = 1'b0;
    logic               command     = 1'b0;
    logic [BLK_W-1:0]   start_block = '0;
    logic [LEN_W-1:0]   length      = '0;
    logic               out_ready   = 1'b0;
    logic               in_ready;
    logic               out_valid;
    logic [1:0]         status;
    logic [BLK_W-1:0]   block;
    logic               last;

    int                 errors      = 0;
    int                 idle_cycles = 0;
    bit                 no_gaps     = 1'b0;
    alloc_scoreboard    sb;

    disk_block_allocator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .start_block (start_block),
        .length      (length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .block       (block),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Monitor: note accepted requests, check accepted results, watchdog
    always @(posedge clk)
    begin
        string msg;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(command, start_block, length);
            if (out_valid && out_ready)
            begin
                if (!sb.check_result(status, block, last, msg))
                    report(msg);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("tb_disk_block_allocator NOT OK");
                $finish;
            end
        end
    end

    // Result side: random stall before each result item, none when no_gaps is set
    initial
    begin
        int n;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            n = no_gaps ? 0 : $urandom_range(0, 6);
            if (n > 0)
            begin
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // Offer one request item after a random gap (none when no_gaps is set) and wait for acceptance
    task automatic send_item(input logic cmd, input logic [BLK_W-1:0] s,
                             input logic [LEN_W-1:0] n);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        start_block <= s;
        length      <= n;
        do @(posedge clk); while (!(in_valid && in_ready));
    endtask

    // Drain: all owed results in, then let a trailing clear finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.owed.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic set_mode(input logic m);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.mode    = m;
    endtask

    // Random request: mostly free start blocks and short files
    task automatic send_random_request();
        logic [BLK_W-1:0] s;
        logic [LEN_W-1:0] n;
        int               tries;
        int               r;
        s = BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
        if ($urandom_range(0, 9) < 7)
        begin
            tries = 0;
            while (sb.used_map[s] && tries < 16)
            begin
                s = BLK_W'($urandom_range(0, NUM_BLOCKS - 1));
                tries++;
            end
        end
        r = $urandom_range(0, 19);
        if (r < 14)
            n = LEN_W'($urandom_range(0, 8));
        else if (r < 19)
            n = LEN_W'($urandom_range(0, MAX_LENGTH));
        else
            n = LEN_W'(MAX_LENGTH);
        send_item(CMD_ALLOC, s, n);
    endtask

    // Stimulus
    initial
    begin
        int k;
        int per_phase;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: contiguous mode
        set_mode(MODE_CONTIG);
        send_item(CMD_ALLOC, 7'd0, 6'd0);       // zero length, marks nothing
        send_item(CMD_ALLOC, 7'd0, 6'd63);      // longest run from block 0
        send_item(CMD_ALLOC, 7'd10, 6'd1);      // start busy
        send_item(CMD_ALLOC, 7'd63, 6'd63);
        send_item(CMD_ALLOC, 7'd126, 6'd5);     // run past end of store
        send_item(CMD_ALLOC, 7'd126, 6'd2);     // fills up to the last block
        send_item(CMD_ALLOC, 7'd127, 6'd1);
        send_item(CMD_CLEAR, 7'd127, 6'd63);
        send_item(CMD_ALLOC, 7'd127, 6'd1);
        send_item(CMD_ALLOC, 7'd100, 6'd30);
        send_item(CMD_ALLOC, 7'd120, 6'd7);
        send_item(CMD_ALLOC, 7'd119, 6'd2);     // run hits a used block

        // Directed: indexed mode
        set_mode(MODE_INDEXED);
        send_item(CMD_CLEAR, 7'd0, 6'd0);
        send_item(CMD_ALLOC, 7'd0, 6'd0);       // index only
        send_item(CMD_ALLOC, 7'd5, 6'd3);
        send_item(CMD_ALLOC, 7'd5, 6'd1);       // index busy
        send_item(CMD_ALLOC, 7'd127, 6'd63);
        send_item(CMD_ALLOC, 7'd126, 6'd63);    // store runs full mid request
        send_item(CMD_ALLOC, 7'd0, 6'd5);
        send_item(CMD_CLEAR, 7'd85, 6'd42);

        // Random phases alternating the mode
        per_phase = RAND_ITEMS / PHASES;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            set_mode((phase % 2) ? MODE_INDEXED : MODE_CONTIG);
            no_gaps = (phase == 1) || ($urandom_range(0, 4) == 0);
            send_item(CMD_CLEAR, BLK_W'($urandom_range(0, NUM_BLOCKS - 1)),
                      LEN_W'($urandom_range(0, MAX_LENGTH)));
            k = 0;
            while (k < per_phase)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(CMD_CLEAR, BLK_W'($urandom_range(0, NUM_BLOCKS - 1)),
                              LEN_W'($urandom_range(0, MAX_LENGTH)));
                else
                begin
                    send_random_request();
                    k++;
                end
            end
        end

        wait_idle();
        if (sb.owed.size() != 0)
            report($sformatf("%0d results never arrived", sb.owed.size()));
        if (errors == 0)
            $display("tb_disk_block_allocator OK");
        else
            $display("tb_disk_block_allocator NOT OK");
        $finish;
    end

endmodule
